/* rtl/pep_pkg.sv */
package pep_pkg;

  localparam int unsigned MAX_TAB_STOPS = 32;
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned QAW           = $clog2(QDEPTH);

  localparam logic [3:0] ACT_NONE    = 4'd0;
  localparam logic [3:0] ACT_CHAR    = 4'd1;
  localparam logic [3:0] ACT_BS      = 4'd2;
  localparam logic [3:0] ACT_TAB     = 4'd3;
  localparam logic [3:0] ACT_LF      = 4'd4;
  localparam logic [3:0] ACT_FF      = 4'd5;
  localparam logic [3:0] ACT_CR      = 4'd6;
  localparam logic [3:0] ACT_GFX     = 4'd7;
  localparam logic [3:0] ACT_SKIP    = 4'd8;
  localparam logic [3:0] ACT_INIT    = 4'd9;
  localparam logic [3:0] ACT_INTERP  = 4'd10;
  localparam logic [3:0] ACT_TABSTOP = 4'd11;
  localparam logic [3:0] ACT_FORMLEN = 4'd12;

  localparam logic [0:0] REG_ALT_TABLE = 1'd0;
  localparam logic [0:0] REG_MAX_FORM  = 1'd1;

  localparam logic [7:0] C_BS  = 8'h08;
  localparam logic [7:0] C_HT  = 8'h09;
  localparam logic [7:0] C_LF  = 8'h0A;
  localparam logic [7:0] C_VT  = 8'h0B;
  localparam logic [7:0] C_FF  = 8'h0C;
  localparam logic [7:0] C_CR  = 8'h0D;
  localparam logic [7:0] C_SO  = 8'h0E;
  localparam logic [7:0] C_SI  = 8'h0F;
  localparam logic [7:0] C_DC2 = 8'h12;
  localparam logic [7:0] C_DC4 = 8'h14;
  localparam logic [7:0] C_ESC = 8'h1B;

  localparam logic [7:0] E_MASTER  = 8'h21;
  localparam logic [7:0] E_UNDER   = 8'h2D;
  localparam logic [7:0] E_SP8     = 8'h30;
  localparam logic [7:0] E_SP7     = 8'h31;
  localparam logic [7:0] E_SP6     = 8'h32;
  localparam logic [7:0] E_SPN     = 8'h33;
  localparam logic [7:0] E_ITAL_ON = 8'h34;
  localparam logic [7:0] E_ITAL_OF = 8'h35;
  localparam logic [7:0] E_TBL_ALT = 8'h36;
  localparam logic [7:0] E_TBL_ONE = 8'h37;
  localparam logic [7:0] E_DLOAD   = 8'h3D;
  localparam logic [7:0] E_INIT    = 8'h40;
  localparam logic [7:0] E_SPA     = 8'h41;
  localparam logic [7:0] E_FORM    = 8'h43;
  localparam logic [7:0] E_TABS    = 8'h44;
  localparam logic [7:0] E_BOLD_ON = 8'h45;
  localparam logic [7:0] E_BOLD_OF = 8'h46;
  localparam logic [7:0] E_DS_ON   = 8'h47;
  localparam logic [7:0] E_DS_OF   = 8'h48;
  localparam logic [7:0] E_NLQ     = 8'h49;
  localparam logic [7:0] E_SKIP    = 8'h4A;
  localparam logic [7:0] E_GFX_K   = 8'h4B;
  localparam logic [7:0] E_GFX_L   = 8'h4C;
  localparam logic [7:0] E_ELITE   = 8'h4D;
  localparam logic [7:0] E_SKIPPERF = 8'h4E;
  localparam logic [7:0] E_SCRIPT  = 8'h53;
  localparam logic [7:0] E_SCR_OFF = 8'h54;
  localparam logic [7:0] E_UNIDIR  = 8'h55;
  localparam logic [7:0] E_DWIDTH  = 8'h57;
  localparam logic [7:0] E_GFX_Y   = 8'h59;
  localparam logic [7:0] E_GFX_Z   = 8'h5A;
  localparam logic [7:0] E_PITCH   = 8'h5B;
  localparam logic [7:0] E_NLQSEL  = 8'h78;
  localparam logic [7:0] E_EXT     = 8'h7E;

  localparam int unsigned SF_DWIDTH  = 0;
  localparam int unsigned SF_ITALIC  = 1;
  localparam int unsigned SF_BOLD    = 2;
  localparam int unsigned SF_DSTRIKE = 3;
  localparam int unsigned SF_UNDER   = 4;
  localparam int unsigned SF_NLQ     = 5;
  localparam int unsigned SF_REVERSE = 6;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] value;
    logic [4:0]  slot;
    logic [2:0]  pitch;
    logic [6:0]  style_flags;
    logic [1:0]  script_mode;
    logic [9:0]  line_spacing;
    logic [2:0]  char_table;
    logic [1:0]  graphics_density;
  } res_t;

endpackage

/* rtl/printer_escape_sequence_parser.sv */
// printer command parser: one data byte per beat in, one result beat out per byte
// (action event plus the print modes after that byte). a byte is taken every cycle
// while full is low; the parser updates its state in the cycle of the push and the
// result is written into a four-entry result queue whose head drives the out_ ports.
// input stalls only when four results wait unpopped. configuration writes take
// effect at once and belong in idle periods.
module printer_escape_sequence_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_action,
  output logic [15:0] out_value,
  output logic [4:0]  out_slot,
  output logic [2:0]  out_pitch,
  output logic [6:0]  out_style_flags,
  output logic [1:0]  out_script_mode,
  output logic [9:0]  out_line_spacing,
  output logic [2:0]  out_char_table,
  output logic [1:0]  out_graphics_density,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  pep_pkg::res_t res, head;
  logic          take;

  assign take = in_push && !in_full;

  pep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  pep_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (take),
    .wdata (res),
    .full  (in_full),
    .rd    (out_pop),
    .empty (out_empty),
    .rdata (head)
  );

  assign out_action           = head.action;
  assign out_value            = head.value;
  assign out_slot             = head.slot;
  assign out_pitch            = head.pitch;
  assign out_style_flags      = head.style_flags;
  assign out_script_mode      = head.script_mode;
  assign out_line_spacing     = head.line_spacing;
  assign out_char_table       = head.char_table;
  assign out_graphics_density = head.graphics_density;

endmodule

/* rtl/pep_front.sv */
module pep_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output pep_pkg::res_t      res
);

  typedef enum logic [2:0] {
    ST_PLAIN = 3'b001,
    ST_ESC   = 3'b010,
    ST_PARAM = 3'b100
  } pstate_t;

  localparam logic [16:0] CNT_MAX = 17'h1FFFF;

  pstate_t     state_r, state_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [16:0] cnt_r, cnt_nxt, cnt_inc;
  logic [15:0] word_r, word_nxt, word_hi;
  logic [2:0]  pitch_r, pitch_nxt;
  logic [6:0]  style_r, style_nxt;
  logic [1:0]  script_r, script_nxt;
  logic [9:0]  spacing_r, spacing_nxt;
  logic [2:0]  table_r, table_nxt;
  logic [1:0]  dens_r, dens_nxt;
  logic [2:0]  alt_r, alt_cfg;
  logic [15:0] maxf_r;
  logic [3:0]  act;
  logic [15:0] val;
  logic [4:0]  slot;
  logic [17:0] prod;
  logic [16:0] cnt_m1;
  logic [7:0]  cmd;
  logic [7:0]  num;
  logic        gfx;
  logic [1:0]  gfx_dens;

  always_comb begin
    unique case (cfg_data[2:0])
      3'd0:    alt_cfg = 3'd1;
      3'd7:    alt_cfg = 3'd6;
      default: alt_cfg = cfg_data[2:0];
    endcase
  end

  assign cnt_inc = (cnt_r < CNT_MAX) ? cnt_r + 17'd1 : cnt_r;
  assign cnt_m1  = cnt_inc - 17'd1;
  assign word_hi = word_r | {data_byte, 8'h00};
  assign cmd     = (word_r[7:0] >= 8'h30) ? word_r[7:0] - 8'h30 : word_r[7:0];
  assign num     = (data_byte >= 8'h30) ? data_byte - 8'h30 : data_byte;
  assign prod    = (cnt_inc == 17'd1) ? 18'(data_byte) * 18'(spacing_r)
                                      : 18'(data_byte) * 18'd216;

  always_comb begin
    gfx      = 1'b1;
    gfx_dens = 2'd0;
    unique case (code_r)
      pep_pkg::E_GFX_K: gfx_dens = 2'd0;
      pep_pkg::E_GFX_L: gfx_dens = 2'd1;
      pep_pkg::E_GFX_Y: gfx_dens = 2'd2;
      pep_pkg::E_GFX_Z: gfx_dens = 2'd3;
      default:          gfx = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    code_nxt    = code_r;
    cnt_nxt     = cnt_r;
    word_nxt    = word_r;
    pitch_nxt   = pitch_r;
    style_nxt   = style_r;
    script_nxt  = script_r;
    spacing_nxt = spacing_r;
    table_nxt   = table_r;
    dens_nxt    = dens_r;
    act         = pep_pkg::ACT_NONE;
    val         = 16'd0;
    slot        = 5'd0;
    unique case (state_r)
      ST_ESC: begin
        code_nxt  = data_byte;
        cnt_nxt   = 17'd0;
        state_nxt = ST_PLAIN;
        unique case (data_byte)
          pep_pkg::C_SO:      style_nxt[pep_pkg::SF_DWIDTH] = 1'b1;
          pep_pkg::E_SP8:     spacing_nxt = 10'd27;
          pep_pkg::E_SP7:     spacing_nxt = 10'd21;
          pep_pkg::E_SP6:     spacing_nxt = 10'd36;
          pep_pkg::E_ITAL_ON: style_nxt[pep_pkg::SF_ITALIC] = 1'b1;
          pep_pkg::E_ITAL_OF: style_nxt[pep_pkg::SF_ITALIC] = 1'b0;
          pep_pkg::E_TBL_ALT: table_nxt = alt_r;
          pep_pkg::E_TBL_ONE: table_nxt = 3'd0;
          pep_pkg::E_INIT: begin
            pitch_nxt   = 3'd0;
            style_nxt   = 7'd0;
            script_nxt  = 2'd0;
            spacing_nxt = 10'd36;
            table_nxt   = 3'd0;
            dens_nxt    = 2'd0;
            act         = pep_pkg::ACT_INIT;
          end
          pep_pkg::E_BOLD_ON: style_nxt[pep_pkg::SF_BOLD] = 1'b1;
          pep_pkg::E_BOLD_OF: style_nxt[pep_pkg::SF_BOLD] = 1'b0;
          pep_pkg::E_DS_ON:   style_nxt[pep_pkg::SF_DSTRIKE] = 1'b1;
          pep_pkg::E_DS_OF:   style_nxt[pep_pkg::SF_DSTRIKE] = 1'b0;
          pep_pkg::E_ELITE:   pitch_nxt = 3'd1;
          pep_pkg::E_SCR_OFF: script_nxt = 2'd0;
          pep_pkg::E_MASTER, pep_pkg::E_UNDER, pep_pkg::E_SPN, pep_pkg::E_DLOAD,
          pep_pkg::E_SPA, pep_pkg::E_FORM, pep_pkg::E_TABS, pep_pkg::E_NLQ,
          pep_pkg::E_SKIP, pep_pkg::E_GFX_K, pep_pkg::E_GFX_L, pep_pkg::E_SKIPPERF,
          pep_pkg::E_SCRIPT, pep_pkg::E_UNIDIR, pep_pkg::E_DWIDTH, pep_pkg::E_GFX_Y,
          pep_pkg::E_GFX_Z, pep_pkg::E_PITCH, pep_pkg::E_NLQSEL, pep_pkg::E_EXT:
            state_nxt = ST_PARAM;
          default: ;
        endcase
      end
      ST_PARAM: begin
        cnt_nxt = cnt_inc;
        if (gfx) begin
          if (cnt_inc == 17'd1) begin
            word_nxt = 16'(data_byte);
            dens_nxt = gfx_dens;
          end else if (cnt_inc == 17'd2) begin
            word_nxt = word_hi;
            if (word_hi == 16'd0) state_nxt = ST_PLAIN;
          end else begin
            act = pep_pkg::ACT_GFX;
            val = 16'(data_byte);
            if (cnt_inc - 17'd2 >= 17'(word_r)) state_nxt = ST_PLAIN;
          end
        end else begin
          unique case (code_r)
            pep_pkg::E_MASTER: begin
              pitch_nxt = data_byte[0] ? 3'd1 : (data_byte[2] ? 3'd2 : 3'd0);
              style_nxt[pep_pkg::SF_UNDER]   = data_byte[7];
              style_nxt[pep_pkg::SF_ITALIC]  = data_byte[6];
              style_nxt[pep_pkg::SF_DWIDTH]  = data_byte[5];
              style_nxt[pep_pkg::SF_DSTRIKE] = data_byte[4];
              style_nxt[pep_pkg::SF_BOLD]    = data_byte[3];
              state_nxt = ST_PLAIN;
            end
            pep_pkg::E_UNDER: begin
              style_nxt[pep_pkg::SF_UNDER] = data_byte[0];
              state_nxt = ST_PLAIN;
            end
            pep_pkg::E_SPN: begin
              spacing_nxt = 10'(data_byte);
              state_nxt   = ST_PLAIN;
            end
            pep_pkg::E_SPA: begin
              spacing_nxt = 10'(data_byte) * 10'd3;
              state_nxt   = ST_PLAIN;
            end
            pep_pkg::E_DLOAD: begin
              if (cnt_inc == 17'd1) begin
                word_nxt = 16'(data_byte);
              end else if (cnt_inc == 17'd2) begin
                word_nxt = word_hi;
                if (word_hi == 16'd0) state_nxt = ST_PLAIN;
              end else if (cnt_inc >= 17'(word_r) + 17'd2) begin
                state_nxt = ST_PLAIN;
              end
            end
            pep_pkg::E_FORM: begin
              if (cnt_inc != 17'd1 || data_byte != 8'd0) begin
                state_nxt = ST_PLAIN;
                if (cnt_inc == 17'd1 || (data_byte != 8'd0 && data_byte < 8'd23)) begin
                  act = pep_pkg::ACT_FORMLEN;
                  val = (prod > 18'(maxf_r)) ? maxf_r : prod[15:0];
                end
              end
            end
            pep_pkg::E_TABS: begin
              if (data_byte == 8'd0 || (cnt_inc > 17'd1 && 16'(data_byte) < word_r) ||
                  cnt_inc > 17'(pep_pkg::MAX_TAB_STOPS)) begin
                state_nxt = ST_PLAIN;
              end else begin
                word_nxt = 16'(data_byte);
                act      = pep_pkg::ACT_TABSTOP;
                val      = 16'(data_byte);
                slot     = cnt_m1[4:0];
              end
            end
            pep_pkg::E_NLQ: begin
              if (data_byte == 8'h00 || data_byte == 8'h30 ||
                  data_byte == 8'h04 || data_byte == 8'h34)
                style_nxt[pep_pkg::SF_NLQ] = 1'b0;
              if (data_byte == 8'h02 || data_byte == 8'h32 ||
                  data_byte == 8'h06 || data_byte == 8'h36)
                style_nxt[pep_pkg::SF_NLQ] = 1'b1;
              state_nxt = ST_PLAIN;
            end
            pep_pkg::E_SKIP: begin
              act       = pep_pkg::ACT_SKIP;
              val       = 16'(data_byte);
              state_nxt = ST_PLAIN;
            end
            pep_pkg::E_SCRIPT: begin
              script_nxt = data_byte[0] ? 2'd2 : 2'd1;
              state_nxt  = ST_PLAIN;
            end
            pep_pkg::E_DWIDTH: begin
              style_nxt[pep_pkg::SF_DWIDTH] = data_byte[0];
              state_nxt = ST_PLAIN;
            end
            pep_pkg::E_PITCH: begin
              if (data_byte[3:0] < 4'd7) pitch_nxt = data_byte[2:0];
              state_nxt = ST_PLAIN;
            end
            pep_pkg::E_NLQSEL: begin
              style_nxt[pep_pkg::SF_NLQ] = data_byte[0];
              state_nxt = ST_PLAIN;
            end
            pep_pkg::E_EXT: begin
              if (cnt_inc == 17'd1) begin
                word_nxt = 16'(data_byte);
              end else begin
                state_nxt = ST_PLAIN;
                if (word_r[15:8] == 8'd0 && cmd == 8'd2) begin
                  style_nxt[pep_pkg::SF_REVERSE] = data_byte[0];
                end else if (word_r[15:8] == 8'd0 && cmd == 8'd3) begin
                  if (data_byte[3:0] < 4'd7) pitch_nxt = data_byte[2:0];
                end else if (word_r[15:8] == 8'd0 && cmd == 8'd5 && num <= 8'd3) begin
                  act = pep_pkg::ACT_INTERP;
                  val = 16'(num);
                end
              end
            end
            default: state_nxt = ST_PLAIN;
          endcase
        end
      end
      default: begin
        state_nxt = ST_PLAIN;
        code_nxt  = data_byte;
        cnt_nxt   = 17'd0;
        unique case (data_byte)
          pep_pkg::C_BS:  act = pep_pkg::ACT_BS;
          pep_pkg::C_HT:  act = pep_pkg::ACT_TAB;
          pep_pkg::C_LF, pep_pkg::C_VT: act = pep_pkg::ACT_LF;
          pep_pkg::C_FF:  act = pep_pkg::ACT_FF;
          pep_pkg::C_CR:  act = pep_pkg::ACT_CR;
          pep_pkg::C_SO:  style_nxt[pep_pkg::SF_DWIDTH] = 1'b1;
          pep_pkg::C_SI:  pitch_nxt = 3'd2;
          pep_pkg::C_DC2: pitch_nxt = 3'd0;
          pep_pkg::C_DC4: style_nxt[pep_pkg::SF_DWIDTH] = 1'b0;
          pep_pkg::C_ESC: state_nxt = ST_ESC;
          default: begin
            if (data_byte >= 8'h20 &&
                !(table_r == 3'd0 && data_byte >= 8'h80 && data_byte <= 8'h9F)) begin
              act = pep_pkg::ACT_CHAR;
              val = 16'(data_byte);
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_PLAIN;
      code_r    <= 8'd0;
      cnt_r     <= 17'd0;
      word_r    <= 16'd0;
      pitch_r   <= 3'd0;
      style_r   <= 7'd0;
      script_r  <= 2'd0;
      spacing_r <= 10'd36;
      table_r   <= 3'd0;
      dens_r    <= 2'd0;
      alt_r     <= 3'd1;
      maxf_r    <= 16'd2376;
    end else if (cfg_we) begin
      if (cfg_index == pep_pkg::REG_ALT_TABLE) begin
        alt_r <= alt_cfg;
        if (table_r != 3'd0) table_r <= alt_cfg;
      end else begin
        maxf_r <= cfg_data;
      end
    end else if (take) begin
      state_r   <= state_nxt;
      code_r    <= code_nxt;
      cnt_r     <= cnt_nxt;
      word_r    <= word_nxt;
      pitch_r   <= pitch_nxt;
      style_r   <= style_nxt;
      script_r  <= script_nxt;
      spacing_r <= spacing_nxt;
      table_r   <= table_nxt;
      dens_r    <= dens_nxt;
    end
  end

  always_comb begin
    res.action           = act;
    res.value            = val;
    res.slot             = slot;
    res.pitch            = pitch_nxt;
    res.style_flags      = style_nxt;
    res.script_mode      = script_nxt;
    res.line_spacing     = spacing_nxt;
    res.char_table       = table_nxt;
    res.graphics_density = dens_nxt;
  end

endmodule

/* rtl/pep_queue.sv */
module pep_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  pep_pkg::res_t wdata,
  output logic          full,
  input  logic          rd,
  output logic          empty,
  output pep_pkg::res_t rdata
);

  pep_pkg::res_t           mem [pep_pkg::QDEPTH];
  logic [pep_pkg::QAW-1:0] wp_r, rp_r;
  logic [pep_pkg::QAW:0]   cnt_r;
  logic                    do_wr, do_rd;

  assign full  = (cnt_r == (pep_pkg::QAW+1)'(pep_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + pep_pkg::QAW'(1);
      if (do_rd) rp_r <= rp_r + pep_pkg::QAW'(1);
      if (do_wr && !do_rd) cnt_r <= cnt_r + (pep_pkg::QAW+1)'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - (pep_pkg::QAW+1)'(1);
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import pep_pkg::*;

  typedef enum logic [1:0] {PS_PLAIN, PS_ESC, PS_PARAM} pstate_t;

  localparam int unsigned LIMIT_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [3:0]  out_action;
  logic [15:0] out_value;
  logic [4:0]  out_slot;
  logic [2:0]  out_pitch;
  logic [6:0]  out_style_flags;
  logic [1:0]  out_script_mode;
  logic [9:0]  out_line_spacing;
  logic [2:0]  out_char_table;
  logic [1:0]  out_graphics_density;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_ALT_TABLE;
  logic [15:0] cfg_data = 16'd0;

  printer_escape_sequence_parser u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data_byte(in_data_byte),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_action(out_action), .out_value(out_value), .out_slot(out_slot),
    .out_pitch(out_pitch), .out_style_flags(out_style_flags),
    .out_script_mode(out_script_mode), .out_line_spacing(out_line_spacing),
    .out_char_table(out_char_table), .out_graphics_density(out_graphics_density),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // parser shadow state
  logic [2:0]  alt_tbl;
  logic [15:0] form_cap;
  pstate_t     pst;
  logic [7:0]  ecode;
  logic [16:0] pcnt;
  logic [15:0] pword;
  logic [2:0]  pitch_q;
  logic [6:0]  style_q;
  logic [1:0]  script_q;
  logic [9:0]  spacing_q;
  logic [2:0]  table_q;
  logic [1:0]  density_q;

  logic [7:0] pending_bytes[$];
  res_t       expected_results[$];
  int         errors = 0;
  int         bytes_sent = 0;
  int         results_seen = 0;
  int         cycles = 0;
  int         snd_idle = 0;
  int         rcv_idle = 0;
  int         hold_gen = 0;
  int         hold_seen = 0;
  int         hold_cnt = 0;

  function automatic logic [2:0] clamp_tbl(input logic [2:0] v);
    if (v == 3'd0) return 3'd1;
    if (v > 3'd6) return 3'd6;
    return v;
  endfunction

  function automatic void modes_clear();
    pitch_q = 3'd0;
    style_q = 7'd0;
    script_q = 2'd0;
    spacing_q = 10'd36;
    table_q = 3'd0;
    density_q = 2'd0;
  endfunction

  function automatic logic [15:0] cap_len(input int unsigned len);
    return (len > form_cap) ? form_cap : len[15:0];
  endfunction

  function automatic void pitch_code(input logic [7:0] b);
    if (b[3:0] < 4'd7) pitch_q = b[2:0];
  endfunction

  function automatic void gfx_byte(input logic [7:0] b, input logic [1:0] dens,
                                   inout res_t r);
    if (pcnt == 17'd1) begin
      pword = {8'd0, b};
      density_q = dens;
    end else if (pcnt == 17'd2) begin
      pword = pword | {b, 8'd0};
      if (pword == 16'd0) pst = PS_PLAIN;
    end else begin
      r.action = ACT_GFX;
      r.value = {8'd0, b};
      if (int'(pcnt) - 2 >= int'(pword)) pst = PS_PLAIN;
    end
  endfunction

  function automatic res_t parse_byte(input logic [7:0] b);
    res_t r;
    int unsigned cmd;
    int unsigned n;
    r = '0;
    if (pst == PS_ESC) begin
      ecode = b;
      pcnt = '0;
      pst = PS_PLAIN;
      case (b)
        C_SO:      style_q[SF_DWIDTH] = 1'b1;
        E_SP8:     spacing_q = 10'd27;
        E_SP7:     spacing_q = 10'd21;
        E_SP6:     spacing_q = 10'd36;
        E_ITAL_ON: style_q[SF_ITALIC] = 1'b1;
        E_ITAL_OF: style_q[SF_ITALIC] = 1'b0;
        E_TBL_ALT: table_q = clamp_tbl(alt_tbl);
        E_TBL_ONE: table_q = 3'd0;
        E_INIT: begin
          modes_clear();
          r.action = ACT_INIT;
        end
        E_BOLD_ON: style_q[SF_BOLD] = 1'b1;
        E_BOLD_OF: style_q[SF_BOLD] = 1'b0;
        E_DS_ON:   style_q[SF_DSTRIKE] = 1'b1;
        E_DS_OF:   style_q[SF_DSTRIKE] = 1'b0;
        E_ELITE:   pitch_q = 3'd1;
        E_SCR_OFF: script_q = 2'd0;
        E_MASTER, E_UNDER, E_SPN, E_DLOAD, E_SPA, E_FORM, E_TABS, E_NLQ, E_SKIP,
        E_GFX_K, E_GFX_L, E_SKIPPERF, E_SCRIPT, E_UNIDIR, E_DWIDTH, E_GFX_Y,
        E_GFX_Z, E_PITCH, E_NLQSEL, E_EXT:
          pst = PS_PARAM;
        default: ;
      endcase
    end else if (pst == PS_PARAM) begin
      if (pcnt != 17'h1FFFF) pcnt = pcnt + 17'd1;
      case (ecode)
        E_MASTER: begin
          pitch_q = 3'd0;
          if (b[2]) pitch_q = 3'd2;
          if (b[0]) pitch_q = 3'd1;
          style_q[SF_UNDER] = b[7];
          style_q[SF_ITALIC] = b[6];
          style_q[SF_DWIDTH] = b[5];
          style_q[SF_DSTRIKE] = b[4];
          style_q[SF_BOLD] = b[3];
          pst = PS_PLAIN;
        end
        E_UNDER: begin
          style_q[SF_UNDER] = b[0];
          pst = PS_PLAIN;
        end
        E_SPN: begin
          spacing_q = {2'd0, b};
          pst = PS_PLAIN;
        end
        E_SPA: begin
          spacing_q = 10'(int'(b) * 3);
          pst = PS_PLAIN;
        end
        E_DLOAD: begin
          if (pcnt == 17'd1) pword = {8'd0, b};
          else if (pcnt == 17'd2) begin
            pword = pword | {b, 8'd0};
            if (pword == 16'd0) pst = PS_PLAIN;
          end else if (int'(pcnt) >= int'(pword) + 2) pst = PS_PLAIN;
        end
        E_FORM: begin
          if (pcnt == 17'd1) begin
            if (b != 8'd0) begin
              r.action = ACT_FORMLEN;
              r.value = cap_len(int'(b) * int'(spacing_q));
              pst = PS_PLAIN;
            end
          end else begin
            if (b > 8'd0 && b < 8'd23) begin
              r.action = ACT_FORMLEN;
              r.value = cap_len(int'(b) * 216);
            end
            pst = PS_PLAIN;
          end
        end
        E_TABS: begin
          if (b == 8'd0 || (pcnt > 17'd1 && {8'd0, b} < pword) ||
              pcnt > 17'(MAX_TAB_STOPS)) begin
            pst = PS_PLAIN;
          end else begin
            pword = {8'd0, b};
            r.action = ACT_TABSTOP;
            r.value = {8'd0, b};
            r.slot = 5'(pcnt - 17'd1);
          end
        end
        E_NLQ: begin
          if (b == 8'h00 || b == 8'h30 || b == 8'h04 || b == 8'h34)
            style_q[SF_NLQ] = 1'b0;
          if (b == 8'h02 || b == 8'h32 || b == 8'h06 || b == 8'h36)
            style_q[SF_NLQ] = 1'b1;
          pst = PS_PLAIN;
        end
        E_SKIP: begin
          r.action = ACT_SKIP;
          r.value = {8'd0, b};
          pst = PS_PLAIN;
        end
        E_GFX_K: gfx_byte(b, 2'd0, r);
        E_GFX_L: gfx_byte(b, 2'd1, r);
        E_GFX_Y: gfx_byte(b, 2'd2, r);
        E_GFX_Z: gfx_byte(b, 2'd3, r);
        E_SCRIPT: begin
          script_q = b[0] ? 2'd2 : 2'd1;
          pst = PS_PLAIN;
        end
        E_DWIDTH: begin
          style_q[SF_DWIDTH] = b[0];
          pst = PS_PLAIN;
        end
        E_PITCH: begin
          pitch_code(b);
          pst = PS_PLAIN;
        end
        E_NLQSEL: begin
          style_q[SF_NLQ] = b[0];
          pst = PS_PLAIN;
        end
        E_EXT: begin
          if (pcnt == 17'd1) pword = {8'd0, b};
          else begin
            cmd = 32'(pword);
            if (cmd >= 32'h30) cmd -= 32'h30;
            if (cmd == 2) style_q[SF_REVERSE] = b[0];
            else if (cmd == 3) pitch_code(b);
            else if (cmd == 5) begin
              n = 32'((b >= 8'h30) ? b - 8'h30 : b);
              if (n <= 3) begin
                r.action = ACT_INTERP;
                r.value = n[15:0];
              end
            end
            pst = PS_PLAIN;
          end
        end
        default: pst = PS_PLAIN;
      endcase
    end else begin
      pst = PS_PLAIN;
      ecode = b;
      pcnt = '0;
      case (b)
        C_BS: r.action = ACT_BS;
        C_HT: r.action = ACT_TAB;
        C_LF, C_VT: r.action = ACT_LF;
        C_FF: r.action = ACT_FF;
        C_CR: r.action = ACT_CR;
        C_SO: style_q[SF_DWIDTH] = 1'b1;
        C_SI: pitch_q = 3'd2;
        C_DC2: pitch_q = 3'd0;
        C_DC4: style_q[SF_DWIDTH] = 1'b0;
        C_ESC: pst = PS_ESC;
        default:
          if (b >= 8'h20 && !(table_q == 3'd0 && b >= 8'h80 && b <= 8'h9F)) begin
            r.action = ACT_CHAR;
            r.value = {8'd0, b};
          end
      endcase
    end
    r.pitch = pitch_q;
    r.style_flags = style_q;
    r.script_mode = script_q;
    r.line_spacing = spacing_q;
    r.char_table = table_q;
    r.graphics_density = density_q;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_push && !in_full) begin
        expected_results.push_back(parse_byte(in_data_byte));
        void'(pending_bytes.pop_front());
        bytes_sent <= bytes_sent + 1;
      end
      if (in_push && in_full) begin
        in_push <= 1'b1;
      end else if (pending_bytes.size() > 0 && $urandom_range(99) >= snd_idle) begin
        in_push <= 1'b1;
        in_data_byte <= pending_bytes[0];
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, action %0d", $time, out_action);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("action", 32'(e.action), 32'(out_action));
          check_field("value", 32'(e.value), 32'(out_value));
          check_field("slot", 32'(e.slot), 32'(out_slot));
          check_field("pitch", 32'(e.pitch), 32'(out_pitch));
          check_field("style_flags", 32'(e.style_flags), 32'(out_style_flags));
          check_field("script_mode", 32'(e.script_mode), 32'(out_script_mode));
          check_field("line_spacing", 32'(e.line_spacing), 32'(out_line_spacing));
          check_field("char_table", 32'(e.char_table), 32'(out_char_table));
          check_field("graphics_density", 32'(e.graphics_density),
                      32'(out_graphics_density));
        end
      end
      if (hold_seen != hold_gen) begin
        hold_seen <= hold_gen;
        hold_cnt <= 300;
        out_pop <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic put(input logic [7:0] b);
    pending_bytes.push_back(b);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [15:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ALT_TABLE) begin
      alt_tbl = clamp_tbl(d[2:0]);
      if (table_q != 3'd0) table_q = alt_tbl;
    end else begin
      form_cap = d;
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic gfx_seq(input logic [7:0] code, input int len);
    put(C_ESC);
    put(code);
    put(len[7:0]);
    put(len[15:8]);
    for (int i = 0; i < len; i++) put(8'($urandom_range(255)));
  endtask

  // one random sequence, mostly well formed
  task automatic rand_seq();
    int k;
    int col;
    int len;
    logic [7:0] codes[] = '{E_MASTER, E_UNDER, E_SPN, E_SPA, E_NLQ, E_SKIP, E_SCRIPT,
                            E_DWIDTH, E_PITCH, E_NLQSEL, E_SKIPPERF, E_UNIDIR};
    logic [7:0] simple[] = '{C_SO, E_SP8, E_SP7, E_SP6, E_ITAL_ON, E_ITAL_OF,
                             E_TBL_ALT, E_TBL_ONE, E_INIT, E_BOLD_ON, E_BOLD_OF,
                             E_DS_ON, E_DS_OF, E_ELITE, E_SCR_OFF, 8'h4F};
    k = $urandom_range(99);
    if (k < 25) begin
      put(8'($urandom_range(255)));
    end else if (k < 35) begin
      put(8'($urandom_range(8'h1F)));
    end else if (k < 50) begin
      put(C_ESC);
      put(simple[$urandom_range(simple.size() - 1)]);
    end else if (k < 62) begin
      put(C_ESC);
      put(codes[$urandom_range(codes.size() - 1)]);
      put(8'($urandom_range(255)));
    end else if (k < 72) begin
      case ($urandom_range(3))
        0: gfx_seq(E_GFX_K, $urandom_range(6));
        1: gfx_seq(E_GFX_L, $urandom_range(6));
        2: gfx_seq(E_GFX_Y, $urandom_range(6));
        default: gfx_seq(E_GFX_Z, $urandom_range(6));
      endcase
    end else if (k < 76) begin
      gfx_seq(E_DLOAD, $urandom_range(5));
    end else if (k < 82) begin
      put(C_ESC);
      put(E_FORM);
      if ($urandom_range(1)) put(8'($urandom_range(255)));
      else begin
        put(8'd0);
        put(8'($urandom_range(25)));
      end
    end else if (k < 90) begin
      put(C_ESC);
      put(E_TABS);
      col = 0;
      len = ($urandom_range(9) == 0) ? 36 : $urandom_range(6);
      for (int i = 0; i < len; i++) begin
        col = col + $urandom_range(6);
        if (col > 255) col = 255;
        put(col[7:0]);
      end
      if ($urandom_range(1)) put(8'd0);
      else put(8'($urandom_range(255)));
    end else begin
      put(C_ESC);
      put(E_EXT);
      len = $urandom_range(7);
      put($urandom_range(1) ? len[7:0] : 8'(len + 8'h30));
      if ($urandom_range(1)) put(8'($urandom_range(5)));
      else put(8'($urandom_range(255)));
    end
  endtask

  task automatic rand_phase(input int n, input int si, input int ri);
    int start;
    snd_idle = si;
    rcv_idle = ri;
    start = bytes_sent + pending_bytes.size();
    while (bytes_sent + pending_bytes.size() - start < n) begin
      rand_seq();
      while (pending_bytes.size() > 64) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    alt_tbl = 3'd1;
    form_cap = 16'd2376;
    pst = PS_PLAIN;
    ecode = '0;
    pcnt = '0;
    pword = '0;
    modes_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_cfg(REG_ALT_TABLE, 16'd3);
    write_cfg(REG_MAX_FORM, 16'd2376);

    // directed opening
    put(8'h20); put(8'hFF); put(8'h80); put(8'h9F); put(8'h00);
    put(C_ESC); put(E_TBL_ALT); put(8'h80);
    put(C_ESC); put(8'h4F);
    put(C_ESC); put(E_GFX_K); put(8'd0); put(8'd0);
    put(C_ESC); put(E_FORM); put(8'd0); put(8'd22);
    put(C_ESC); put(E_FORM); put(8'd0); put(8'd23);
    put(C_ESC); put(E_FORM); put(8'd255);
    put(C_ESC); put(E_TABS); put(8'd10); put(8'd20); put(8'd5);
    put(C_ESC); put(E_NLQ); put(8'h02);
    put(C_ESC); put(E_PITCH); put(8'h0F);
    put(C_ESC); put(E_EXT); put(8'h35); put(8'h37);
    put(C_ESC); put(E_EXT); put(8'h05); put(8'h33);
    put(C_ESC); put(E_INIT);
    snd_idle = 27;
    rcv_idle = 47;
    drain();

    write_cfg(REG_ALT_TABLE, 16'd0);
    write_cfg(REG_MAX_FORM, 16'd0);
    rand_phase(450, 27, 47);

    write_cfg(REG_ALT_TABLE, 16'hFFFF);
    write_cfg(REG_MAX_FORM, 16'hFFFF);
    rand_phase(450, 47, 27);

    // long receiver stall while bytes keep coming
    hold_gen = hold_gen + 1;
    write_cfg(REG_ALT_TABLE, 16'd4);
    write_cfg(REG_MAX_FORM, 16'd100);
    rand_phase(400, 0, 0);

    write_cfg(REG_ALT_TABLE, 16'd6);
    write_cfg(REG_MAX_FORM, 16'd3000);
    rand_phase(400, 10, 10);

    $display("sent %0d bytes, checked %0d result beats", bytes_sent, results_seen);
    $display("covered plain, escape and parameter sequences under 5 register settings");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
